// ===== src/cfd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the CRC byte function of the CRC-checked frame deframer.
package cfd_pkg;

    localparam int unsigned HDR_LEN = 28;
    localparam int unsigned POS_W   = 5;
    localparam int unsigned CRC_OFS = 24;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;
    localparam logic [31:0] MAGIC    = 32'h4854_4252;

    localparam logic [7:0]  VERSION_RST     = 8'd1;
    localparam logic [31:0] MAX_PAYLOAD_RST = 32'd65536;
    localparam logic [63:0] TYPE_MASK_RST   = 64'h0000_0000_0000_7FFF;

    typedef logic [HDR_LEN-1:0][7:0] t_hdr;

    typedef enum logic [1:0] {
        CFG_VERSION     = 2'd0,
        CFG_MAX_PAYLOAD = 2'd1,
        CFG_TYPE_MASK   = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_HDR_OK     = 2'd0,
        KIND_PAYLOAD    = 2'd1,
        KIND_HDR_REJECT = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_MAGIC   = 3'd1,
        ERR_VERSION = 3'd2,
        ERR_TYPE    = 3'd3,
        ERR_FLAGS   = 3'd4,
        ERR_LENGTH  = 3'd5,
        ERR_CRC     = 3'd6
    } t_err;

    typedef struct packed {
        logic [7:0]  msg_type;
        logic [31:0] seq;
        logic [31:0] len;
        logic [63:0] time_ns;
        logic        crc_ok;
        t_err        err;
    } t_hdr_info;

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] v;
        v = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

endpackage

// ===== src/cfd_req_if.sv =====
`timescale 1ns / 1ps
// Request channel: stream bytes and discard commands into the deframer.
interface cfd_req_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;

    modport source(output valid, command, data_byte, input ready);
    modport sink(input valid, command, data_byte, output ready);
endinterface

// ===== src/cfd_res_if.sv =====
`timescale 1ns / 1ps
// Result channel: header verdicts and forwarded payload bytes out of the deframer.
interface cfd_res_if;
    logic           valid;
    logic           ready;
    cfd_pkg::t_kind result_kind;
    logic [7:0]     payload_byte;
    logic           frame_end;
    cfd_pkg::t_err  fault_code;
    logic [7:0]     message_type;
    logic [31:0]    sequence_number;
    logic [63:0]    time_ns;
    logic [31:0]    payload_length;
    logic [31:0]    dropped_count;

    modport source(output valid, result_kind, payload_byte, frame_end, fault_code,
                   message_type, sequence_number, time_ns, payload_length,
                   dropped_count, input ready);
    modport sink(input valid, result_kind, payload_byte, frame_end, fault_code,
                 message_type, sequence_number, time_ns, payload_length,
                 dropped_count, output ready);
endinterface

// ===== src/cfd_hdr_check.sv =====
`timescale 1ns / 1ps
// Header field extraction, CRC compare and ordered header checks.
module cfd_hdr_check (
    input  cfd_pkg::t_hdr      i_hdr,
    input  logic [31:0]        i_crc,
    input  logic [7:0]         i_version,
    input  logic [31:0]        i_max_payload,
    input  logic [63:0]        i_type_mask,
    output cfd_pkg::t_hdr_info o_info
);

    logic [31:0] magic;
    logic [31:0] crc_field;
    logic [7:0]  msg_type;
    logic        type_bad;

    always_comb begin
        magic     = {i_hdr[0], i_hdr[1], i_hdr[2], i_hdr[3]};
        crc_field = {i_hdr[cfd_pkg::CRC_OFS], i_hdr[cfd_pkg::CRC_OFS+1],
                     i_hdr[cfd_pkg::CRC_OFS+2], i_hdr[cfd_pkg::CRC_OFS+3]};
        msg_type  = i_hdr[5];
        type_bad  = (msg_type[7:6] != 2'd0) || !i_type_mask[msg_type[5:0]];

        o_info.msg_type = msg_type;
        o_info.seq      = {i_hdr[8], i_hdr[9], i_hdr[10], i_hdr[11]};
        o_info.len      = {i_hdr[12], i_hdr[13], i_hdr[14], i_hdr[15]};
        o_info.time_ns  = {i_hdr[16], i_hdr[17], i_hdr[18], i_hdr[19],
                           i_hdr[20], i_hdr[21], i_hdr[22], i_hdr[23]};
        o_info.crc_ok   = ((i_crc ^ cfd_pkg::CRC_ONES) == crc_field);

        priority if (magic != cfd_pkg::MAGIC) begin
            o_info.err = cfd_pkg::ERR_MAGIC;
        end else if (i_hdr[4] != i_version) begin
            o_info.err = cfd_pkg::ERR_VERSION;
        end else if (type_bad) begin
            o_info.err = cfd_pkg::ERR_TYPE;
        end else if (i_hdr[6] != 8'd0 || i_hdr[7] != 8'd0) begin
            o_info.err = cfd_pkg::ERR_FLAGS;
        end else if (o_info.len > i_max_payload) begin
            o_info.err = cfd_pkg::ERR_LENGTH;
        end else if (o_info.len == 32'd0 && !o_info.crc_ok) begin
            o_info.err = cfd_pkg::ERR_CRC;
        end else begin
            o_info.err = cfd_pkg::ERR_NONE;
        end
    end

endmodule

// ===== src/crc_checked_frame_deframer.sv =====
`timescale 1ns / 1ps
// Top level: CRC-checked length-prefixed frame deframer.
//
//   channel   dir  handshake         payload
//   i_req     in   valid/ready       command, data_byte
//   o_res     out  valid/ready       result_kind .. dropped_count
//   i_cfg_*   in   write enable      i_cfg_idx, i_cfg_data
//
// One request per cycle while i_req.ready is high; each request updates the frame state in the cycle it
// is taken and any result lands in the output register at that same edge.
// i_req.ready drops only while a result sits in the output register unclaimed.
// Synchronous active-low reset; the header store holds no reset value.
module crc_checked_frame_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    cfd_req_if.sink     i_req,
    cfd_res_if.source   o_res
);

    logic [7:0]  r_version;
    logic [31:0] r_max_payload;
    logic [63:0] r_type_mask;

    logic [cfd_pkg::POS_W-1:0] r_pos,       n_pos;
    logic                      r_in_payload, n_in_payload;
    logic [31:0]               r_remaining, n_remaining;
    logic [31:0]               r_crc,       n_crc;
    logic [31:0]               r_drops,     n_drops;
    cfd_pkg::t_hdr             r_hdr,       n_hdr;

    logic                      r_out_valid;
    cfd_pkg::t_kind            r_out_kind,  n_kind;
    logic [7:0]                r_out_byte,  n_byte;
    logic                      r_out_end,   n_end;
    cfd_pkg::t_err             r_out_err,   n_err;
    logic [7:0]                r_out_type;
    logic [31:0]               r_out_seq;
    logic [63:0]               r_out_time;
    logic [31:0]               r_out_len;
    logic [31:0]               r_out_drops;

    logic               acc;
    logic               n_res;
    logic [7:0]         crc_in;
    logic [31:0]        crc_upd;
    cfd_pkg::t_hdr_info info;

    assign i_req.ready = !r_out_valid || o_res.ready;
    assign acc         = i_req.valid && i_req.ready;

    cfd_hdr_check u_check (
        .i_hdr         (n_hdr),
        .i_crc         (crc_upd),
        .i_version     (r_version),
        .i_max_payload (r_max_payload),
        .i_type_mask   (r_type_mask),
        .o_info        (info)
    );

    always_comb begin
        // CRC field bytes enter the CRC as zero
        crc_in  = (r_in_payload || r_pos < cfd_pkg::POS_W'(cfd_pkg::CRC_OFS))
                  ? i_req.data_byte : 8'd0;
        crc_upd = cfd_pkg::crc_byte(r_crc, crc_in);

        n_hdr = r_hdr;
        if (!r_in_payload) begin
            n_hdr[r_pos] = i_req.data_byte;
        end

        n_pos        = r_pos;
        n_in_payload = r_in_payload;
        n_remaining  = r_remaining;
        n_crc        = r_crc;
        n_drops      = r_drops;
        n_res        = 1'b0;
        n_kind       = cfd_pkg::KIND_HDR_OK;
        n_byte       = 8'd0;
        n_end        = 1'b0;
        n_err        = cfd_pkg::ERR_NONE;

        if (acc) begin
            priority if (i_req.command) begin
                n_pos        = '0;
                n_in_payload = 1'b0;
                n_remaining  = 32'd0;
                n_crc        = cfd_pkg::CRC_ONES;
            end else if (r_in_payload) begin
                n_res       = 1'b1;
                n_kind      = cfd_pkg::KIND_PAYLOAD;
                n_byte      = i_req.data_byte;
                n_crc       = crc_upd;
                n_remaining = r_remaining - 32'd1;
                if (r_remaining == 32'd1) begin
                    n_end = 1'b1;
                    if (!info.crc_ok) begin
                        n_err   = cfd_pkg::ERR_CRC;
                        n_drops = r_drops + 32'd1;
                    end
                    n_pos        = '0;
                    n_in_payload = 1'b0;
                    n_remaining  = 32'd0;
                    n_crc        = cfd_pkg::CRC_ONES;
                end
            end else begin
                n_crc = crc_upd;
                n_pos = r_pos + cfd_pkg::POS_W'(1);
                if (r_pos == cfd_pkg::POS_W'(cfd_pkg::HDR_LEN - 1)) begin
                    n_res = 1'b1;
                    n_err = info.err;
                    priority if (info.err != cfd_pkg::ERR_NONE) begin
                        n_kind  = cfd_pkg::KIND_HDR_REJECT;
                        n_end   = 1'b1;
                        n_drops = r_drops + 32'd1;
                        n_pos   = '0;
                        n_crc   = cfd_pkg::CRC_ONES;
                    end else if (info.len == 32'd0) begin
                        n_end = 1'b1;
                        n_pos = '0;
                        n_crc = cfd_pkg::CRC_ONES;
                    end else begin
                        n_pos        = '0;
                        n_in_payload = 1'b1;
                        n_remaining  = info.len;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version     <= cfd_pkg::VERSION_RST;
            r_max_payload <= cfd_pkg::MAX_PAYLOAD_RST;
            r_type_mask   <= cfd_pkg::TYPE_MASK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cfd_pkg::CFG_VERSION:     r_version     <= i_cfg_data[7:0];
                cfd_pkg::CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data[31:0];
                cfd_pkg::CFG_TYPE_MASK:   r_type_mask   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_in_payload <= 1'b0;
            r_remaining  <= 32'd0;
            r_crc        <= cfd_pkg::CRC_ONES;
            r_drops      <= 32'd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_pos        <= n_pos;
            r_in_payload <= n_in_payload;
            r_remaining  <= n_remaining;
            r_crc        <= n_crc;
            r_drops      <= n_drops;
            if (acc && n_res) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr <= n_hdr;
        if (acc && n_res) begin
            r_out_kind  <= n_kind;
            r_out_byte  <= n_byte;
            r_out_end   <= n_end;
            r_out_err   <= n_err;
            r_out_type  <= info.msg_type;
            r_out_seq   <= info.seq;
            r_out_time  <= info.time_ns;
            r_out_len   <= info.len;
            r_out_drops <= n_drops;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.result_kind     = r_out_kind;
    assign o_res.payload_byte    = r_out_byte;
    assign o_res.frame_end       = r_out_end;
    assign o_res.fault_code      = r_out_err;
    assign o_res.message_type    = r_out_type;
    assign o_res.sequence_number = r_out_seq;
    assign o_res.time_ns         = r_out_time;
    assign o_res.payload_length  = r_out_len;
    assign o_res.dropped_count   = r_out_drops;

    a_payload_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_payload |-> (r_pos == '0 && r_remaining != 32'd0))
        else $error("payload state with header position or zero remaining");

    a_reject_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == cfd_pkg::KIND_HDR_REJECT) |->
        (r_out_end && r_out_err != cfd_pkg::ERR_NONE))
        else $error("rejected header without frame end or error code");

    a_drop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && n_res && n_err != cfd_pkg::ERR_NONE) |=>
        (r_drops == $past(r_drops) + 32'd1))
        else $error("drop counter did not advance on error");

    a_restart_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && n_res && n_end) |=> (r_crc == cfd_pkg::CRC_ONES && !r_in_payload))
        else $error("frame closed without CRC restart");

endmodule
